// ===== hdl/chacha_pkg.sv =====
`default_nettype none
package chacha_pkg;
    localparam int DoubleRoundsDef = 10;
    localparam logic [31:0] Sigma0 = 32'h61707865;
    localparam logic [31:0] Sigma1 = 32'h3320646e;
    localparam logic [31:0] Sigma2 = 32'h79622d32;
    localparam logic [31:0] Sigma3 = 32'h6b206574;
    localparam logic [32:0] CtrLimit = 33'h0FFFFFFFF;

    // register indexes
    localparam logic [2:0] RegKey0   = 3'd0;
    localparam logic [2:0] RegKey1   = 3'd1;
    localparam logic [2:0] RegKey2   = 3'd2;
    localparam logic [2:0] RegKey3   = 3'd3;
    localparam logic [2:0] RegNonce0 = 3'd4;
    localparam logic [2:0] RegNonce1 = 3'd5;
    localparam logic [2:0] RegStart  = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic load;    // load initial state from key, nonce, counter
        logic round;   // apply one half double round
        logic diag;    // half round is diagonal
        logic finish;  // add input words, store keystream
    } t_cmd;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter(input logic [127:0] q);
        logic [31:0] a, b, c, d;
        a = q[31:0]; b = q[63:32]; c = q[95:64]; d = q[127:96];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter = {d, c, b, a};
    endfunction
endpackage
`default_nettype wire

// ===== hdl/chacha_dp.sv =====
`default_nettype none
module chacha_dp (
    input  wire logic           i_clk,
    input  wire chacha_pkg::t_cmd i_cmd,
    input  wire logic [255:0]   i_key,
    input  wire logic [95:0]    i_nonce,
    input  wire logic [31:0]    i_ctr,
    input  wire logic [5:0]     i_pos,
    output logic [7:0]          o_ks_byte
);
    import chacha_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_init [16];
    logic [31:0] r_ks [16];
    logic [31:0] w_init [16];
    logic [31:0] w_rnd [16];
    logic [127:0] w_q [4];
    logic [31:0] w_word;

    // assemble the initial state
    always_comb begin
        w_init[0] = Sigma0; w_init[1] = Sigma1; w_init[2] = Sigma2; w_init[3] = Sigma3;
        for (int i = 0; i < 8; i++) w_init[4+i] = i_key[32*i +: 32];
        w_init[12] = i_ctr;
        for (int i = 0; i < 3; i++) w_init[13+i] = i_nonce[32*i +: 32];
    end

    // four quarter-round units, column or diagonal wiring
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_cmd.diag) begin
                w_q[k] = quarter({r_w[12 + ((k+3)%4)], r_w[8 + ((k+2)%4)],
                                  r_w[4 + ((k+1)%4)], r_w[k]});
            end else begin
                w_q[k] = quarter({r_w[12+k], r_w[8+k], r_w[4+k], r_w[k]});
            end
        end
        for (int i = 0; i < 16; i++) w_rnd[i] = r_w[i];
        for (int k = 0; k < 4; k++) begin
            w_rnd[k] = w_q[k][31:0];
            if (i_cmd.diag) begin
                w_rnd[4 + ((k+1)%4)]  = w_q[k][63:32];
                w_rnd[8 + ((k+2)%4)]  = w_q[k][95:64];
                w_rnd[12 + ((k+3)%4)] = w_q[k][127:96];
            end else begin
                w_rnd[4+k]  = w_q[k][63:32];
                w_rnd[8+k]  = w_q[k][95:64];
                w_rnd[12+k] = w_q[k][127:96];
            end
        end
    end

    // working state, saved input, keystream
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w <= w_init;
            r_init <= w_init;
        end else if (i_cmd.round) begin
            r_w <= w_rnd;
        end
        if (i_cmd.finish) begin
            for (int i = 0; i < 16; i++) r_ks[i] <= r_w[i] + r_init[i];
        end
    end

    // select keystream byte
    assign w_word = r_ks[i_pos[5:2]];
    assign o_ks_byte = w_word[8*i_pos[1:0] +: 8];
endmodule
`default_nettype wire

// ===== hdl/chacha_ctrl.sv =====
`default_nettype none
module chacha_ctrl #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDef
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_data,
    output logic            o_last,
    output logic            o_ovf,
    input  wire logic [31:0] i_start,
    input  wire logic [7:0] i_ks_byte,
    output chacha_pkg::t_cmd o_cmd,
    output logic [31:0]     o_ctr,
    output logic [5:0]      o_pos
);
    import chacha_pkg::*;

    localparam int HalfW = $clog2(2*DOUBLE_ROUNDS + 1);
    localparam logic [HalfW-1:0] LastHalf = HalfW'(2*DOUBLE_ROUNDS - 1);

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StRound = 2'd1;
    localparam logic [1:0] StFin   = 2'd2;
    localparam logic [1:0] StOut   = 2'd3;

    logic [1:0] r_st, n_st;
    logic [HalfW-1:0] r_half;
    logic [5:0] r_pos;
    logic [32:0] r_ctr;
    logic r_ovf, r_inmsg;
    logic [7:0] r_data;
    logic r_last;
    logic r_ov_valid;
    logic [7:0] r_odata;
    logic r_olast, r_oovf;
    logic w_acc, w_out_free;
    logic [32:0] w_ctr;
    logic [5:0] w_pos;
    logic w_ovf;

    assign w_out_free = !r_ov_valid || i_ready;
    assign o_ready = (r_st == StIdle);
    assign w_acc = i_valid && o_ready;
    // effective state at message start
    assign w_ctr = r_inmsg ? r_ctr : {1'b0, i_start};
    assign w_pos = r_inmsg ? r_pos : 6'd0;
    assign w_ovf = r_inmsg ? r_ovf : 1'b0;

    // hand the counter of the block being started to the datapath
    assign o_ctr = w_ctr[31:0];
    assign o_pos = r_pos;
    assign o_cmd.load = (r_st == StIdle) && w_acc && (w_pos == 6'd0) && !w_ovf
                        && (w_ctr <= CtrLimit);
    assign o_cmd.round = (r_st == StRound);
    assign o_cmd.diag = r_half[0];
    assign o_cmd.finish = (r_st == StFin);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            StIdle:  if (w_acc) n_st = o_cmd.load ? StRound : StOut;
            StRound: if (r_half == LastHalf) n_st = StFin;
            StFin:   n_st = StOut;
            StOut:   if (w_out_free) n_st = StIdle;
            default: n_st = StIdle;
        endcase
    end

    // sequence, position, counter and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_half <= '0;
            r_pos <= '0;
            r_ctr <= '0;
            r_ovf <= 1'b0;
            r_inmsg <= 1'b0;
            r_ov_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov_valid && i_ready) r_ov_valid <= 1'b0;
            if (w_acc) begin
                r_data <= i_data;
                r_last <= i_last;
                r_inmsg <= 1'b1;
                r_pos <= w_pos;
                r_ctr <= w_ctr;
                r_ovf <= w_ovf;
                r_half <= '0;
                if (w_pos == 6'd0 && !w_ovf) begin
                    if (w_ctr > CtrLimit) r_ovf <= 1'b1;
                    else r_ctr <= w_ctr + 33'd1;
                end
            end
            if (r_st == StRound) r_half <= r_half + 1'b1;
            // drive the result and advance position
            if (r_st == StOut && w_out_free) begin
                r_ov_valid <= 1'b1;
                r_odata <= r_ovf ? r_data : (r_data ^ i_ks_byte);
                r_olast <= r_last;
                r_oovf <= r_ovf;
                r_pos <= r_pos + 6'd1;
                if (r_last) begin
                    r_inmsg <= 1'b0;
                    r_pos <= '0;
                    r_ovf <= 1'b0;
                end
            end
        end
    end

    assign o_valid = r_ov_valid;
    assign o_data = r_odata;
    assign o_last = r_olast;
    assign o_ovf = r_oovf;

    a_round_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == StRound) |-> (r_half <= LastHalf)) else $error("round count");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data))) else $error("out hold");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_st == StRound)) else $error("load seq");
endmodule
`default_nettype wire

// ===== hdl/chacha20_stream_cipher.sv =====
`default_nettype none
// Channel | Direction | Signals
// input   | in        | i_valid, o_ready, i_data_byte, i_end_of_message
// output  | out       | o_valid, i_ready, o_result_byte, o_end_of_message_out,
//         |           | o_counter_overflow
// config  | APB       | psel, penable, pwrite, paddr, pwdata, prdata, pready
// A byte inside a block passes the idle and output states; the first byte of a block
// also runs the round and finish states on the single unit of four quarter rounds.
// Reset is synchronous, active low; configuration registers reset to zero.
// The output register holds a result while i_ready is low; input stalls then.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_result_byte,
    output logic             o_end_of_message_out,
    output logic             o_counter_overflow,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import chacha_pkg::*;

    logic [255:0] r_key;
    logic [95:0] r_nonce;
    logic [31:0] r_start;
    logic [2:0] w_idx;
    t_cmd w_cmd;
    logic [31:0] w_ctr;
    logic [5:0] w_pos;
    logic [7:0] w_ks;

    assign pready = 1'b1;
    assign w_idx = paddr[5:3];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_nonce <= '0;
            r_start <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                RegKey0:   r_key[63:0] <= pwdata;
                RegKey1:   r_key[127:64] <= pwdata;
                RegKey2:   r_key[191:128] <= pwdata;
                RegKey3:   r_key[255:192] <= pwdata;
                RegNonce0: r_nonce[63:0] <= pwdata;
                RegNonce1: r_nonce[95:64] <= pwdata[31:0];
                RegStart:  r_start <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            RegKey0:   prdata = r_key[63:0];
            RegKey1:   prdata = r_key[127:64];
            RegKey2:   prdata = r_key[191:128];
            RegKey3:   prdata = r_key[255:192];
            RegNonce0: prdata = r_nonce[63:0];
            RegNonce1: prdata = {32'd0, r_nonce[95:64]};
            RegStart:  prdata = {32'd0, r_start};
            default:   prdata = '0;
        endcase
    end

    chacha_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_data(i_data_byte), .i_last(i_end_of_message),
        .o_valid, .i_ready,
        .o_data(o_result_byte), .o_last(o_end_of_message_out),
        .o_ovf(o_counter_overflow),
        .i_start(r_start), .i_ks_byte(w_ks),
        .o_cmd(w_cmd), .o_ctr(w_ctr), .o_pos(w_pos)
    );

    chacha_dp u_dp (
        .i_clk, .i_cmd(w_cmd), .i_key(r_key), .i_nonce(r_nonce),
        .i_ctr(w_ctr), .i_pos(w_pos), .o_ks_byte(w_ks)
    );
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import chacha_pkg::*;

    localparam int Rounds = DoubleRoundsDef;
    localparam int SettleCycles = 2 * Rounds + 20;
    localparam longint CycleLimit = 1000000;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic       ovf;
    } t_cipher_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_result_byte;
    logic        o_end_of_message_out;
    logic        o_counter_overflow;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    chacha20_stream_cipher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_end_of_message(i_end_of_message),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_byte(o_result_byte),
        .o_end_of_message_out(o_end_of_message_out),
        .o_counter_overflow(o_counter_overflow),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow configuration
    logic [63:0] key_words [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] first_ctr;

    // shadow cipher state
    logic [31:0] keystream [16];
    logic [31:0] mix_words [16];
    logic [5:0]  byte_pos;
    logic [32:0] block_ctr;
    logic        ovf_seen;
    logic        in_msg;

    t_cipher_out expected_bytes [$];
    int mismatches;
    int bytes_sent;
    int bytes_checked;
    int ovf_results;
    int messages_sent;
    longint cycles;
    bit send_gaps;
    bit sink_stalls;

    function automatic logic [31:0] rot_left(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix(int a, int b, int c, int d);
        mix_words[a] = mix_words[a] + mix_words[b];
        mix_words[d] = rot_left(mix_words[d] ^ mix_words[a], 16);
        mix_words[c] = mix_words[c] + mix_words[d];
        mix_words[b] = rot_left(mix_words[b] ^ mix_words[c], 12);
        mix_words[a] = mix_words[a] + mix_words[b];
        mix_words[d] = rot_left(mix_words[d] ^ mix_words[a], 8);
        mix_words[c] = mix_words[c] + mix_words[d];
        mix_words[b] = rot_left(mix_words[b] ^ mix_words[c], 7);
    endfunction

    function automatic void make_keystream(logic [31:0] ctr);
        logic [31:0] init [16];
        init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
        for (int k = 0; k < 4; k++) begin
            init[4 + 2 * k] = key_words[k][31:0];
            init[5 + 2 * k] = key_words[k][63:32];
        end
        init[12] = ctr;
        init[13] = nonce_lo[31:0];
        init[14] = nonce_lo[63:32];
        init[15] = nonce_hi;
        for (int k = 0; k < 16; k++) mix_words[k] = init[k];
        for (int r = 0; r < Rounds; r++) begin
            mix(0, 4, 8, 12); mix(1, 5, 9, 13); mix(2, 6, 10, 14); mix(3, 7, 11, 15);
            mix(0, 5, 10, 15); mix(1, 6, 11, 12); mix(2, 7, 8, 13); mix(3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++) keystream[k] = mix_words[k] + init[k];
    endfunction

    // advance the shadow cipher by one byte
    function automatic t_cipher_out encrypt_byte(logic [7:0] d, logic last);
        t_cipher_out r;
        logic [31:0] word;
        if (!in_msg) begin
            block_ctr = {1'b0, first_ctr};
            ovf_seen = 1'b0;
            byte_pos = '0;
            in_msg = 1'b1;
        end
        if (byte_pos == 0 && !ovf_seen) begin
            if (block_ctr[32]) begin
                ovf_seen = 1'b1;
            end else begin
                make_keystream(block_ctr[31:0]);
                block_ctr = block_ctr + 33'd1;
            end
        end
        word = keystream[byte_pos[5:2]];
        r.text = ovf_seen ? d : d ^ word[byte_pos[1:0] * 8 +: 8];
        r.last = last;
        r.ovf = ovf_seen;
        byte_pos = byte_pos + 6'd1;
        if (last) begin
            byte_pos = '0;
            block_ctr = {1'b0, first_ctr};
            ovf_seen = 1'b0;
            in_msg = 1'b0;
        end
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_cipher_out exp_out;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result byte %h at %0t", o_result_byte, $realtime);
            end else begin
                exp_out = expected_bytes.pop_front();
                bytes_checked++;
                if (o_counter_overflow) ovf_results++;
                if (o_result_byte !== exp_out.text || o_end_of_message_out !== exp_out.last
                        || o_counter_overflow !== exp_out.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp byte %h last %b ovf %b, got %h %b %b",
                                 exp_out.text, exp_out.last, exp_out.ovf, o_result_byte,
                                 o_end_of_message_out, o_counter_overflow);
                end
            end
        end
    end

    // sink side: when sink stalls are on, stall a random number of cycles before each transfer
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = sink_stalls ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_end_of_message <= last;
        do @(posedge i_clk); while (!o_ready);
        expected_bytes.push_back(encrypt_byte(d, last));
        bytes_sent++;
        if (last) messages_sent++;
    endtask

    // hold off until every result is back, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegKey0:   key_words[0] = val;
            RegKey1:   key_words[1] = val;
            RegKey2:   key_words[2] = val;
            RegKey3:   key_words[3] = val;
            RegNonce0: nonce_lo = val;
            RegNonce1: nonce_hi = val[31:0];
            RegStart:  first_ctr = val[31:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] n0, input logic [31:0] n1,
                             input logic [31:0] ctr);
        drain();
        write_reg(RegKey0, k0);
        write_reg(RegKey1, k1);
        write_reg(RegKey2, k2);
        write_reg(RegKey3, k3);
        write_reg(RegNonce0, n0);
        write_reg(RegNonce1, {32'd0, n1});
        write_reg(RegStart, {32'd0, ctr});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_message(input int len, input bit with_end);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom_range(0, 255)), with_end && k == len - 1);
    endtask

    // reset configuration, short messages and a single-byte message
    task automatic test_reset_config();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b1);
    endtask

    // all-ones key and nonce, counter one below its top, byte extremes
    task automatic test_extremes();
        write_all('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFE);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_all('0, '0, '0, '0, '0, '0, '0);
        send_byte(8'hFF, 1'b1);
    endtask

    // counter runs past its top: flag sets, bytes pass, end mark clears it
    task automatic test_overflow();
        write_all(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(),
                  32'hFFFF_FFFF);
        send_message(70, 1'b1);
        send_message(3, 1'b1);
    endtask

    // key, nonce and start counter change in the middle of a message
    task automatic test_midmessage_write();
        send_message(30, 1'b0);
        drain();
        write_reg(RegKey2, rand64());
        write_reg(RegNonce1, {32'd0, $urandom()});
        write_reg(RegStart, {32'd0, $urandom()});
        send_message(40, 1'b1);
        send_message(5, 1'b1);
    endtask

    // random messages under random settings
    task automatic test_random_traffic();
        int len;
        logic [31:0] ctr;
        while (bytes_sent < 2000) begin
            case ($urandom_range(0, 3))
                0: ctr = 32'hFFFF_FFFF - $urandom_range(0, 2);
                1: ctr = $urandom_range(0, 3);
                default: ctr = $urandom();
            endcase
            write_all(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(), ctr);
            for (int m = 0; m < 4; m++) begin
                send_gaps = $urandom_range(0, 3) != 0;
                sink_stalls = $urandom_range(0, 3) != 0;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 200)
                                                  : $urandom_range(1, 70);
                send_message(len, $urandom_range(0, 7) != 0);
            end
        end
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        bytes_sent = 0;
        bytes_checked = 0;
        ovf_results = 0;
        messages_sent = 0;
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
        for (int k = 0; k < 4; k++) key_words[k] = '0;
        nonce_lo = '0;
        nonce_hi = '0;
        first_ctr = '0;
        byte_pos = '0;
        block_ctr = '0;
        ovf_seen = 1'b0;
        in_msg = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_data_byte <= '0;
        i_end_of_message <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_extremes();
        test_overflow();
        test_midmessage_write();
        test_random_traffic();
        drain();

        $display("sent %0d bytes in %0d closed messages, checked %0d results",
                 bytes_sent, messages_sent, bytes_checked);
        $display("%0d results carried the overflow flag, %0d mismatches",
                 ovf_results, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/chacha_pkg.sv
hdl/chacha_dp.sv
hdl/chacha_ctrl.sv
hdl/chacha20_stream_cipher.sv
dv/tb.sv
